>>> rtl/eidv_pkg.sv
// Package for the endpoint identifier validator.
// Word types, phase encoding, character constants and class helpers; no dependencies.
`timescale 1ns / 1ps

package eidv_pkg;

	localparam logic [7:0]  VCHAR_LOW   = 8'h21;
	localparam logic [7:0]  VCHAR_HIGH  = 8'h7E;
	localparam logic [63:0] U64_DIV10   = 64'd1844674407370955161;
	localparam logic [3:0]  POS_SAT     = 4'd8;
	localparam logic [1:0]  DCNT_SAT    = 2'd2;

	localparam logic [1:0]  SCHEME_UNKNOWN = 2'd0;
	localparam logic [1:0]  SCHEME_DTN     = 2'd1;
	localparam logic [1:0]  SCHEME_IPN     = 2'd2;

	localparam logic [7:0]  CH_D     = 8'h64;
	localparam logic [7:0]  CH_I     = 8'h69;
	localparam logic [7:0]  CH_N     = 8'h6E;
	localparam logic [7:0]  CH_SLASH = 8'h2F;
	localparam logic [7:0]  CH_DOT   = 8'h2E;
	localparam logic [7:0]  CH_DASH  = 8'h2D;
	localparam logic [7:0]  CH_UNDER = 8'h5F;
	localparam logic [7:0]  CH_ZERO  = 8'h30;
	localparam logic [7:0]  CH_NINE  = 8'h39;

	typedef enum logic [12:0] {
		PH_START     = 13'b0000000000001,
		PH_DPFX      = 13'b0000000000010,
		PH_IPFX      = 13'b0000000000100,
		PH_UNK       = 13'b0000000001000,
		PH_DBODY     = 13'b0000000010000,
		PH_DNONE     = 13'b0000000100000,
		PH_DNONE_END = 13'b0000001000000,
		PH_DSL       = 13'b0000010000000,
		PH_DNODE0    = 13'b0000100000000,
		PH_DNODE     = 13'b0001000000000,
		PH_DDEMUX    = 13'b0010000000000,
		PH_INODE     = 13'b0100000000000,
		PH_ISVC      = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic        valid_res;
		logic [1:0]  scheme;
		logic        is_local;
		logic [63:0] ipn_node;
		logic [63:0] ipn_service;
	} out_word_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_node_char(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			is_digit(c) || c == CH_DASH || c == CH_DOT || c == CH_UNDER;
	endfunction

	function automatic logic [7:0] dtn_none_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h64;
			3'd1: c = 8'h74;
			3'd2: c = 8'h6E;
			3'd3: c = 8'h3A;
			3'd4: c = 8'h6E;
			3'd5: c = 8'h6F;
			3'd6: c = 8'h6E;
			default: c = 8'h65;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] ipn_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h69;
			2'd1: c = 8'h70;
			2'd2: c = 8'h6E;
			default: c = 8'h3A;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/eidv_core.sv
// Phase machine and ipn accumulators of the endpoint identifier validator.
// Depends on eidv_pkg; state advances on step, verdict is combinational.
`timescale 1ns / 1ps

module eidv_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  eidv_pkg::in_word_t  word,
	output eidv_pkg::out_word_t verdict
);
	import eidv_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  pos_q, pos_n;
	logic        failed_q, failed_n;
	logic [63:0] node_q, node_n;
	logic [63:0] svc_q, svc_n;
	logic [1:0]  dcnt_q, dcnt_n;
	logic        slash_q, slash_n;

	logic [7:0]  c;
	logic        dig;
	logic [63:0] acc;
	logic [63:0] acc_next;
	logic        acc_ovf;
	logic [1:0]  dcnt_inc;
	logic        node_ok;
	logic        svc_ok;

	assign c   = word.character;
	assign dig = is_digit(c);
	assign acc = (phase_q == PH_INODE) ? node_q : svc_q;
	assign acc_ovf = (acc > U64_DIV10) || (acc == U64_DIV10 && (c - CH_ZERO) > 8'd5);
	assign acc_next = (acc << 3) + (acc << 1) + {60'd0, c[3:0]};
	assign dcnt_inc = (dcnt_q < DCNT_SAT) ? dcnt_q + 2'd1 : dcnt_q;
	assign node_ok = (dcnt_q != 2'd0) && !(node_q == 64'd0 && dcnt_q >= DCNT_SAT);

	always_comb begin
		phase_n  = phase_q;
		pos_n    = (pos_q < POS_SAT) ? pos_q + 4'd1 : pos_q;
		failed_n = failed_q;
		node_n   = node_q;
		svc_n    = svc_q;
		dcnt_n   = dcnt_q;
		slash_n  = slash_q;
		if (!failed_q) begin
			unique case (phase_q)
				PH_START: begin
					if (c == CH_D) phase_n = PH_DPFX;
					else if (c == CH_I) phase_n = PH_IPFX;
					else phase_n = PH_UNK;
				end
				PH_DPFX: begin
					if (pos_q > 4'd3 || c != dtn_none_char(pos_q[2:0])) phase_n = PH_UNK;
					else if (pos_q == 4'd3) phase_n = PH_DBODY;
				end
				PH_IPFX: begin
					if (pos_q > 4'd3 || c != ipn_char(pos_q[1:0])) phase_n = PH_UNK;
					else if (pos_q == 4'd3) phase_n = PH_INODE;
				end
				PH_DBODY: begin
					if (c == CH_N) phase_n = PH_DNONE;
					else if (c == CH_SLASH) phase_n = PH_DSL;
					else failed_n = 1'b1;
				end
				PH_DNONE: begin
					if (pos_q > 4'd7 || c != dtn_none_char(pos_q[2:0])) failed_n = 1'b1;
					else if (pos_q == 4'd7) phase_n = PH_DNONE_END;
				end
				PH_DNONE_END: failed_n = 1'b1;
				PH_DSL: begin
					if (c == CH_SLASH) phase_n = PH_DNODE0;
					else failed_n = 1'b1;
				end
				PH_DNODE0: begin
					if (is_node_char(c)) phase_n = PH_DNODE;
					else failed_n = 1'b1;
				end
				PH_DNODE: begin
					if (c == CH_SLASH) begin
						phase_n = PH_DDEMUX;
						slash_n = 1'b1;
					end else if (!is_node_char(c)) begin
						failed_n = 1'b1;
					end
				end
				PH_DDEMUX: begin
					slash_n = 1'b0;
					if (c < VCHAR_LOW || c > VCHAR_HIGH) failed_n = 1'b1;
				end
				PH_INODE: begin
					if (dig) begin
						if (acc_ovf) failed_n = 1'b1;
						else begin
							node_n = acc_next;
							dcnt_n = dcnt_inc;
						end
					end else if (c == CH_DOT && node_ok) begin
						phase_n = PH_ISVC;
						dcnt_n  = 2'd0;
					end else begin
						failed_n = 1'b1;
					end
				end
				PH_ISVC: begin
					if (!dig || acc_ovf) failed_n = 1'b1;
					else begin
						svc_n  = acc_next;
						dcnt_n = dcnt_inc;
					end
				end
				default: ;
			endcase
		end
	end

	assign svc_ok = (dcnt_n != 2'd0) && !(svc_n == 64'd0 && dcnt_n >= DCNT_SAT);

	always_comb begin
		verdict = '0;
		case (phase_n) inside
			PH_DBODY, PH_DNONE, PH_DNONE_END, PH_DSL, PH_DNODE0, PH_DNODE, PH_DDEMUX: begin
				verdict.scheme = SCHEME_DTN;
				if (!failed_n && (phase_n == PH_DNONE_END || phase_n == PH_DDEMUX)) begin
					verdict.valid_res = 1'b1;
					verdict.is_local  = (phase_n == PH_DDEMUX) && slash_n;
				end
			end
			PH_INODE, PH_ISVC: begin
				verdict.scheme = SCHEME_IPN;
				if (!failed_n && phase_n == PH_ISVC && svc_ok) begin
					verdict.valid_res   = 1'b1;
					verdict.ipn_node    = node_n;
					verdict.ipn_service = svc_n;
					verdict.is_local    = (svc_n == 64'd0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			pos_q    <= '0;
			failed_q <= 1'b0;
			node_q   <= '0;
			svc_q    <= '0;
			dcnt_q   <= '0;
			slash_q  <= 1'b0;
		end else if (step) begin
			if (word.last) begin
				phase_q  <= PH_START;
				pos_q    <= '0;
				failed_q <= 1'b0;
				node_q   <= '0;
				svc_q    <= '0;
				dcnt_q   <= '0;
				slash_q  <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				failed_q <= failed_n;
				node_q   <= node_n;
				svc_q    <= svc_n;
				dcnt_q   <= dcnt_n;
				slash_q  <= slash_n;
			end
		end
	end

endmodule

>>> rtl/endpoint_id_validator.sv
// Endpoint identifier validator, top level: input register, parser, result register.
// Depends on eidv_pkg and eidv_core.
// A verdict enters the result register as its last byte leaves the input register.
// Throughput: one byte per cycle unless out_ready stalls a verdict; the parser step
// is a single compare and a times-ten add between the input and result registers.
// Reset: arst_n clears all control state and returns the parser to the start phase.
`timescale 1ns / 1ps

module endpoint_id_validator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  eidv_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output eidv_pkg::out_word_t out_data
);
	import eidv_pkg::*;

	logic      valid_s1;
	in_word_t  word_s1;
	logic      adv;
	out_word_t verdict;
	logic      out_valid_q;
	out_word_t out_word_q;

	// advance unless a verdict is due and the result register cannot take it
	assign adv      = valid_s1 && (!word_s1.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_data;
		end
	end

	eidv_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.word    (word_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && word_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && word_s1.last) begin
			out_word_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

endmodule

>>> bench/eid_verdict_checker.sv
`timescale 1ns / 1ps
// Verdict checker for endpoint_id_validator: parses every accepted byte with its own
// phase machine and compares each verdict word against the oldest predicted one.
// Depends on eidv_pkg for the word types, phase encoding and limits.

module eid_verdict_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  eidv_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  eidv_pkg::out_word_t out_data,
	output int unsigned         errors,
	output int unsigned         pending
);
	import eidv_pkg::*;

	localparam logic [63:0] NONE_TEXT = "dtn:none";
	localparam logic [31:0] IPN_TEXT  = "ipn:";

	phase_t      p_phase;
	logic [3:0]  p_pos;
	logic        p_dead;
	logic [63:0] p_node;
	logic [63:0] p_svc;
	logic [1:0]  p_ndig;
	logic        p_slash_end;

	out_word_t   verdict_q[$];
	int unsigned n_bad = 0;

	assign errors  = n_bad;
	assign pending = verdict_q.size();

	function automatic logic decimal_ch(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic name_ch(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || decimal_ch(c) ||
			c == "-" || c == "." || c == "_";
	endfunction

	function automatic logic [7:0] none_at(input logic [3:0] i);
		return NONE_TEXT[(7 - i[2:0]) * 8 +: 8];
	endfunction

	function automatic logic num_ok(input logic [63:0] v);
		return p_ndig >= 2'd1 && !(v == 64'd0 && p_ndig >= 2'd2);
	endfunction

	task automatic parser_clear();
		p_phase     = PH_START;
		p_pos       = 4'd0;
		p_dead      = 1'b0;
		p_node      = 64'd0;
		p_svc       = 64'd0;
		p_ndig      = 2'd0;
		p_slash_end = 1'b0;
	endtask

	task automatic take_digit(input logic [3:0] d, inout logic [63:0] acc);
		if (acc > U64_DIV10 || (acc == U64_DIV10 && d > 4'd5)) begin
			p_dead = 1'b1;
		end else begin
			acc = acc * 64'd10 + {60'd0, d};
			if (p_ndig < DCNT_SAT)
				p_ndig = p_ndig + 2'd1;
		end
	endtask

	task automatic parse_byte(input in_word_t w);
		logic [7:0] c;
		logic [3:0] at;
		out_word_t  v;
		c  = w.character;
		at = p_pos;
		if (p_pos < POS_SAT)
			p_pos = p_pos + 4'd1;
		if (!p_dead) begin
			case (p_phase)
				PH_START: begin
					if (c == "d")
						p_phase = PH_DPFX;
					else if (c == "i")
						p_phase = PH_IPFX;
					else
						p_phase = PH_UNK;
				end
				PH_DPFX: begin
					if (at > 4'd3 || c != none_at(at))
						p_phase = PH_UNK;
					else if (at == 4'd3)
						p_phase = PH_DBODY;
				end
				PH_IPFX: begin
					if (at > 4'd3 || c != IPN_TEXT[(3 - at[1:0]) * 8 +: 8])
						p_phase = PH_UNK;
					else if (at == 4'd3)
						p_phase = PH_INODE;
				end
				PH_DBODY: begin
					if (c == "n")
						p_phase = PH_DNONE;
					else if (c == "/")
						p_phase = PH_DSL;
					else
						p_dead = 1'b1;
				end
				PH_DNONE: begin
					if (at > 4'd7 || c != none_at(at))
						p_dead = 1'b1;
					else if (at == 4'd7)
						p_phase = PH_DNONE_END;
				end
				PH_DSL: begin
					if (c == "/")
						p_phase = PH_DNODE0;
					else
						p_dead = 1'b1;
				end
				PH_DNODE0: begin
					if (name_ch(c))
						p_phase = PH_DNODE;
					else
						p_dead = 1'b1;
				end
				PH_DNODE: begin
					if (c == "/") begin
						p_phase     = PH_DDEMUX;
						p_slash_end = 1'b1;
					end else if (!name_ch(c)) begin
						p_dead = 1'b1;
					end
				end
				PH_DDEMUX: begin
					p_slash_end = 1'b0;
					if (c < VCHAR_LOW || c > VCHAR_HIGH)
						p_dead = 1'b1;
				end
				PH_INODE: begin
					if (decimal_ch(c)) begin
						take_digit(c[3:0], p_node);
					end else if (c == "." && num_ok(p_node)) begin
						p_phase = PH_ISVC;
						p_ndig  = 2'd0;
					end else begin
						p_dead = 1'b1;
					end
				end
				PH_ISVC: begin
					if (!decimal_ch(c))
						p_dead = 1'b1;
					else
						take_digit(c[3:0], p_svc);
				end
				PH_DNONE_END: p_dead = 1'b1;
				default: ;
			endcase
		end
		if (w.last) begin
			v = '0;
			if (p_phase inside {PH_DBODY, PH_DNONE, PH_DNONE_END, PH_DSL, PH_DNODE0,
					PH_DNODE, PH_DDEMUX}) begin
				v.scheme = SCHEME_DTN;
				if (!p_dead && (p_phase == PH_DNONE_END || p_phase == PH_DDEMUX)) begin
					v.valid_res = 1'b1;
					v.is_local  = p_phase == PH_DDEMUX && p_slash_end;
				end
			end else if (p_phase == PH_INODE || p_phase == PH_ISVC) begin
				v.scheme = SCHEME_IPN;
				if (!p_dead && p_phase == PH_ISVC && num_ok(p_svc)) begin
					v.valid_res   = 1'b1;
					v.ipn_node    = p_node;
					v.ipn_service = p_svc;
					v.is_local    = p_svc == 64'd0;
				end
			end
			verdict_q.push_back(v);
			parser_clear();
		end
	endtask

	task automatic check_verdict(input out_word_t got);
		out_word_t want;
		if (verdict_q.size() == 0) begin
			if (n_bad < 10)
				$display("%0t: verdict word with none predicted: valid %0b scheme %0d local %0b node %0d service %0d",
					$time, got.valid_res, got.scheme, got.is_local, got.ipn_node,
					got.ipn_service);
			n_bad = n_bad + 1;
		end else begin
			want = verdict_q.pop_front();
			if (got.valid_res !== want.valid_res || got.scheme !== want.scheme ||
					got.is_local !== want.is_local || got.ipn_node !== want.ipn_node ||
					got.ipn_service !== want.ipn_service) begin
				if (n_bad < 10)
					$display("%0t: verdict mismatch: expected valid %0b scheme %0d local %0b node %0d service %0d, got valid %0b scheme %0d local %0b node %0d service %0d",
						$time, want.valid_res, want.scheme, want.is_local, want.ipn_node,
						want.ipn_service, got.valid_res, got.scheme, got.is_local,
						got.ipn_node, got.ipn_service);
				n_bad = n_bad + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parser_clear();
			verdict_q.delete();
		end else begin
			if (out_valid && out_ready)
				check_verdict(out_data);
			if (in_valid && in_ready)
				parse_byte(in_data);
		end
	end

endmodule

>>> bench/tb_endpoint_id_validator.sv
`timescale 1ns / 1ps
// Testbench top for endpoint_id_validator: clock, reset, identifier stimulus and verdict.
// Depends on eidv_pkg, endpoint_id_validator and eid_verdict_checker.

module tb_endpoint_id_validator;
	import eidv_pkg::*;

	localparam int RANDOM_BYTES = 2000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT_CYCLES = 300000;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_word_t    in_data   = '0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_data;
	int unsigned errors;
	int unsigned pending;
	int unsigned cycles     = 0;
	int unsigned bytes_sent = 0;
	int unsigned burst_left = 0;
	logic [7:0]  eid[$];

	always #5 clk = ~clk;

	endpoint_id_validator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	eid_verdict_checker u_verdicts (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("FAIL endpoint_id_validator");
			$finish;
		end
	end

	initial begin
		rx_mode_t mode;
		int       span;
		bit       held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(16, 160);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= $urandom_range(0, 3) == 0;
					default:   out_ready <= (i % 4) != 3;
				endcase
			end
			// hold off long enough for verdicts to back up into the input
			if (!held && bytes_sent >= 600) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
		end
	end

	task automatic put_word(input logic [7:0] c, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= '{character: c, last: is_last};
		do @(posedge clk); while (!in_ready);
		bytes_sent = bytes_sent + 1;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			eid.push_back(s[i]);
	endtask

	task automatic send_eid();
		if (eid.size() == 0)
			eid.push_back("x");
		for (int i = 0; i < eid.size(); i++)
			put_word(eid[i], i == eid.size() - 1);
		eid.delete();
	endtask

	task automatic send_text(input string s);
		add_text(s);
		send_eid();
	endtask

	function automatic string num_text();
		logic [63:0] big;
		big = {$urandom, $urandom};
		case ($urandom_range(0, 10))
			0:  return "0";
			1:  return "00";
			2:  return $sformatf("%0d", $urandom_range(0, 999));
			3:  return $sformatf("00%0d", $urandom_range(1, 99999));
			4:  return $sformatf("%0d", big);
			5:  return "18446744073709551615";
			6:  return $sformatf("1844674407370955161%0d", $urandom_range(0, 9));
			7:  return "";
			8:  return $sformatf("%0d%0d", big, $urandom_range(0, 99));
			9:  return $sformatf("%0d", big >> $urandom_range(1, 63));
			default: return $sformatf("%0d", $urandom_range(1, 9));
		endcase
	endfunction

	function automatic logic [7:0] node_char();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range("a", "z"));
			1: return 8'($urandom_range("A", "Z"));
			2: return 8'($urandom_range("0", "9"));
			3: return "-";
			4: return ".";
			default: return "_";
		endcase
	endfunction

	task automatic make_random_eid();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			add_text("dtn:none");
		end else if (kind < 50) begin
			add_text("dtn://");
			n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
			repeat (n) eid.push_back(node_char());
			eid.push_back("/");
			n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			repeat (n) eid.push_back(8'($urandom_range(VCHAR_LOW, VCHAR_HIGH)));
		end else if (kind < 85) begin
			add_text("ipn:");
			add_text(num_text());
			add_text(".");
			add_text(num_text());
		end else begin
			case ($urandom_range(0, 4))
				0: add_text("d");
				1: add_text("dtn");
				2: add_text("ipn:");
				3: add_text("dtn:/");
				default: ;
			endcase
			repeat ($urandom_range(1, 10)) eid.push_back(8'($urandom_range(1, 255)));
		end
		case ($urandom_range(0, 9))
			0: eid[$urandom_range(0, eid.size() - 1)] = 8'($urandom_range(1, 255));
			1: begin
				n = $urandom_range(1, eid.size());
				while (eid.size() > n)
					eid.pop_back();
			end
			2: eid.push_back(8'($urandom_range(1, 255)));
			default: ;
		endcase
	endtask

	initial begin
		int unsigned directed_bytes;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text("dtn:none");
		send_text("dtn:nonex");
		send_text("dtn:nona");
		send_text("dtn://node/");
		send_text("dtn://a-b.c_D9/svc~!");
		send_text("dtn:///x");
		send_text("dtn://n");
		send_text("dtn://n/ ");
		send_text("ipn:0.0");
		send_text("ipn:1.2");
		send_text("ipn:18446744073709551615.18446744073709551615");
		send_text("ipn:18446744073709551616.1");
		send_text("ipn:00.1");
		send_text("ipn:007.0");
		send_text("ipn:.1");
		send_text("ipn:1.");
		send_text("ipn:1.2x");
		send_text("dtn:");
		send_text("ip");
		send_text("xyz:1");
		eid.push_back(8'h00);
		send_eid();
		add_text("dtn://n/");
		eid.push_back(8'h7F);
		send_eid();
		add_text("dtn://");
		eid.push_back(8'h80);
		add_text("/");
		send_eid();
		eid.push_back(8'hFF);
		send_eid();
		directed_bytes = bytes_sent;

		while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
			make_random_eid();
			send_eid();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS endpoint_id_validator");
		else
			$display("FAIL endpoint_id_validator");
		$finish;
	end

endmodule
